/* rtl/core/vafcr_pkg.sv */
// shared types and constants for the vendor action frame capture ring
`default_nettype none

package vafcr_pkg;

    localparam int RING_DEPTH  = 32;
    localparam int MAX_RESULTS = 32;
    localparam int RING_AW     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int FILL_W      = $clog2(RING_DEPTH + 1);
    localparam int LEFT_W      = $clog2(MAX_RESULTS + 1);

    localparam logic [11:0] MIN_LENGTH = 12'd29;
    localparam logic [7:0]  CAT_VENDOR = 8'h7F;
    localparam logic [23:0] OUI_MATCH  = {8'h18, 8'hFE, 8'h34};
    localparam logic [7:0]  LEN_SAT    = 8'd255;

    localparam int IN_DATA_W  = 144;
    localparam int OUT_DATA_W = 136;

    typedef enum logic [1:0] {
        STS_REJECT = 2'd0,
        STS_STORED = 2'd1,
        STS_RECORD = 2'd2,
        STS_EMPTY  = 2'd3
    } t_status;

    typedef enum logic {
        ST_IDLE,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic        mode;
        logic [47:0] sender_mac;
        logic [7:0]  category;
        logic [23:0] oui;
        logic [11:0] frame_length;
        logic signed [7:0] rssi;
        logic [3:0]  channel;
        logic [31:0] time_ms;
        logic [6:0]  max_count;
    } t_in_item;

    typedef struct packed {
        logic [47:0] mac;
        logic [7:0]  rssi;
        logic [3:0]  channel;
        logic [7:0]  length;
        logic [31:0] time_ms;
    } t_rec;

    typedef struct packed {
        t_status     status;
        t_rec        rec;
        logic [31:0] total_seen;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic accept;
        logic next;
    } t_cmd;

    typedef struct packed {
        logic last;
    } t_sts;

endpackage

`default_nettype wire

/* rtl/core/vendor_action_frame_capture_ring_core.sv */
// top level of the vendor action frame capture ring
//
// input words arrive on s_axis: tuser selects ingest (0) or snapshot (1),
// tdata carries the frame summary and the snapshot record limit.
// results leave on m_axis: tuser is the status code, tlast marks the
// final word for one input word.
// once an input word is taken, its first result is valid the
// next cycle and stays until taken. ingest and an empty snapshot give a
// single word. a snapshot streams min(fill, max_count, 32) records,
// newest first, one per cycle while m_axis_tready is high; each record
// is read from the ring memory on the cycle its predecessor is taken.
// s_axis_tready is low while any result of the current word is pending,
// so a stalled receiver holds the last result and blocks intake.
// a new word is taken only in the idle state that follows the last
// result of the previous word, so intake and output never overlap.
// reset empties the ring (head, fill count and total count to zero);
// ring contents need no clearing, only written entries are ever read.
`default_nettype none

module vendor_action_frame_capture_ring_core (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // mac[47:0] category[55:48] oui[79:56] frame_length[91:80] rssi[99:92]
    // channel[103:100] time_ms[135:104] max_count[142:136] zero[143]
    input  wire  [143:0] s_axis_tdata,
    // mode[0]
    input  wire  [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // out_mac[47:0] out_rssi[55:48] out_channel[59:56] out_length[67:60]
    // out_time[99:68] total_seen[131:100] zero[135:132]
    output logic [135:0] m_axis_tdata,
    // status[1:0]
    output logic [1:0]   m_axis_tuser,
    output logic         m_axis_tlast
);

    vafcr_pkg::t_in_item  in_item;
    vafcr_pkg::t_out_item out_item;
    vafcr_pkg::t_cmd      cmd;
    vafcr_pkg::t_sts      sts;

    always_comb begin
        in_item.mode         = s_axis_tuser[0];
        in_item.sender_mac   = s_axis_tdata[47:0];
        in_item.category     = s_axis_tdata[55:48];
        in_item.oui          = s_axis_tdata[79:56];
        in_item.frame_length = s_axis_tdata[91:80];
        in_item.rssi         = s_axis_tdata[99:92];
        in_item.channel      = s_axis_tdata[103:100];
        in_item.time_ms      = s_axis_tdata[135:104];
        in_item.max_count    = s_axis_tdata[142:136];
    end

    vafcr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    vafcr_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_item  (in_item),
        .o_sts   (sts),
        .o_item  (out_item)
    );

    always_comb begin
        m_axis_tdata = {4'd0,
                        out_item.total_seen,
                        out_item.rec.time_ms,
                        out_item.rec.length,
                        out_item.rec.channel,
                        out_item.rec.rssi,
                        out_item.rec.mac};
        m_axis_tuser = out_item.status;
        m_axis_tlast = out_item.last;
    end

endmodule

`default_nettype wire

/* rtl/core/vafcr_ctrl.sv */
// handshake controller for the capture ring
`default_nettype none

module vafcr_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  wire              i_out_ready,
    input  vafcr_pkg::t_sts  i_sts,
    output vafcr_pkg::t_cmd  o_cmd
);

    vafcr_pkg::t_state r_state;
    vafcr_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vafcr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_out_valid  = 1'b0;
        o_cmd.accept = 1'b0;
        o_cmd.next   = 1'b0;
        unique case (r_state)
            vafcr_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = vafcr_pkg::ST_OUT;
                end
            end
            vafcr_pkg::ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_sts.last) begin
                        n_state = vafcr_pkg::ST_IDLE;
                    end else begin
                        // fetch the next older record as this word leaves
                        o_cmd.next = 1'b1;
                    end
                end
            end
            default: begin
                n_state = vafcr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/vafcr_dp.sv */
// ring storage, counters and output register of the capture ring
`default_nettype none

module vafcr_dp (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  vafcr_pkg::t_cmd       i_cmd,
    input  vafcr_pkg::t_in_item   i_item,
    output vafcr_pkg::t_sts       o_sts,
    output vafcr_pkg::t_out_item  o_item
);

    localparam int AW = vafcr_pkg::RING_AW;
    localparam int FW = vafcr_pkg::FILL_W;
    localparam int LW = vafcr_pkg::LEFT_W;

    vafcr_pkg::t_rec r_mem [vafcr_pkg::RING_DEPTH];

    logic [AW-1:0] r_head;
    logic [AW-1:0] n_head;
    logic [FW-1:0] r_fill;
    logic [FW-1:0] n_fill;
    logic [31:0]   r_total;
    logic [31:0]   n_total;
    logic [AW-1:0] r_rd_slot;
    logic [LW-1:0] r_left;
    vafcr_pkg::t_out_item r_out;

    logic            match;
    logic            wr_en;
    vafcr_pkg::t_rec new_rec;
    logic [AW-1:0]   prev_head;
    logic [AW-1:0]   prev_rd;
    logic [AW-1:0]   rd_slot;
    logic [6:0]      fill_ext;
    logic [6:0]      lim;
    logic [6:0]      lim_clamp;
    logic [LW-1:0]   snap_n;

    always_comb begin
        match = (i_item.frame_length >= vafcr_pkg::MIN_LENGTH)
             && (i_item.category == vafcr_pkg::CAT_VENDOR)
             && (i_item.oui == vafcr_pkg::OUI_MATCH);
        wr_en = i_cmd.accept && !i_item.mode && match;

        new_rec.mac     = i_item.sender_mac;
        new_rec.rssi    = i_item.rssi;
        new_rec.channel = i_item.channel;
        new_rec.length  = (|i_item.frame_length[11:8]) ? vafcr_pkg::LEN_SAT
                                                       : i_item.frame_length[7:0];
        new_rec.time_ms = i_item.time_ms;

        prev_head = (r_head == '0) ? AW'(vafcr_pkg::RING_DEPTH - 1) : r_head - AW'(1);
        prev_rd   = (r_rd_slot == '0) ? AW'(vafcr_pkg::RING_DEPTH - 1)
                                      : r_rd_slot - AW'(1);
        rd_slot   = i_cmd.accept ? prev_head : prev_rd;

        fill_ext  = 7'(r_fill);
        lim       = (i_item.max_count < fill_ext) ? i_item.max_count : fill_ext;
        lim_clamp = (lim > 7'(vafcr_pkg::MAX_RESULTS)) ? 7'(vafcr_pkg::MAX_RESULTS) : lim;
        snap_n    = LW'(lim_clamp);

        n_head  = r_head;
        n_fill  = r_fill;
        n_total = r_total;
        if (wr_en) begin
            n_head  = (r_head == AW'(vafcr_pkg::RING_DEPTH - 1)) ? '0 : r_head + AW'(1);
            n_fill  = (r_fill == FW'(vafcr_pkg::RING_DEPTH)) ? r_fill : r_fill + FW'(1);
            n_total = r_total + 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_fill  <= '0;
            r_total <= '0;
        end else begin
            r_head  <= n_head;
            r_fill  <= n_fill;
            r_total <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_head] <= new_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_out.total_seen <= n_total;
            if (!i_item.mode) begin
                r_out.last <= 1'b1;
                if (match) begin
                    r_out.status <= vafcr_pkg::STS_STORED;
                    r_out.rec    <= new_rec;
                end else begin
                    r_out.status <= vafcr_pkg::STS_REJECT;
                    r_out.rec    <= '0;
                end
            end else if (snap_n == '0) begin
                r_out.status <= vafcr_pkg::STS_EMPTY;
                r_out.rec    <= '0;
                r_out.last   <= 1'b1;
            end else begin
                r_out.status <= vafcr_pkg::STS_RECORD;
                r_out.rec    <= r_mem[rd_slot];
                r_out.last   <= (snap_n == LW'(1));
                r_left       <= snap_n - LW'(1);
                r_rd_slot    <= rd_slot;
            end
        end else if (i_cmd.next) begin
            r_out.rec  <= r_mem[rd_slot];
            r_out.last <= (r_left == LW'(1));
            r_left     <= r_left - LW'(1);
            r_rd_slot  <= rd_slot;
        end
    end

    assign o_sts.last = r_out.last;
    assign o_item     = r_out;

endmodule

`default_nettype wire
